@@ hw/rtl/hsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants for the heading slew block
// Angle formats, CORDIC lane layout, arctangent constants and bearing rounding.
// ----------------------------------------------------------------------------
package hsc_pkg;

  // cordic length and accumulator width (one turn = 2^ANGLE_BITS)
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;

  // coordinate scaling inside the cordic
  localparam int COORD_FRAC = 24;
  // 17-bit differences, growth below 2.4, sign bit
  localparam int CW         = COORD_FRAC + 21;
  localparam int SIDX_W     = $clog2(CORDIC_STAGES);
  localparam int TABLE_LEN  = 24;

  // gain factor, Q1.20 clamped at one
  localparam int FACT_W = 21;
  localparam logic [FACT_W-1:0] ONE_Q20 = FACT_W'(1) << 20;

  // product of magnitude and factor
  localparam int PROD_W = 16 + FACT_W;

  // bearing rounding shifts
  localparam int BRG_UP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
  localparam int BRG_DN = (ANGLE_BITS > 16) ? (ANGLE_BITS - 16) : 1;

  // half turn in accumulator units
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // one item travelling down the cordic chain
  typedef struct packed {
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic [ANGLE_BITS-1:0]  z;
    logic [15:0]            heading;
    logic [FACT_W-1:0]      factor;
    logic                   same;
  } lane_t;

  // arctangent constant rounded half up to the accumulator width
  function automatic logic [ANGLE_BITS-1:0] atan_const(input logic [4:0] idx);
    logic [32:0] t;
    t = 33'd0;
    if (idx < 5'(TABLE_LEN)) begin
      t = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (32 - ANGLE_BITS - 1));
    end
    return ANGLE_BITS'(t >> (32 - ANGLE_BITS));
  endfunction

  // accumulator angle to a 16-bit binary angle, rounding half up when the accumulator is wider
  function automatic logic [15:0] bearing16(input logic [ANGLE_BITS-1:0] z);
    logic [24:0] w;
    w = 25'(z);
    if (ANGLE_BITS <= 16) begin
      return 16'(w << BRG_UP);
    end
    return 16'((w + (25'd1 << (BRG_DN - 1))) >> BRG_DN);
  endfunction

endpackage

@@ hw/rtl/hsc_prep.sv @@
// ----------------------------------------------------------------------------
// hsc_prep: entry stage of the heading slew pipeline
// Forms the offset vector, folds it into the right half plane and clamps gain.
// ----------------------------------------------------------------------------
module hsc_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [15:0]   aim_x,
  input  logic signed [15:0]   aim_y,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  logic [15:0]          heading,
  input  logic [15:0]          elapsed_time,
  input  logic [15:0]          turn_rate,
  output logic                 dn_valid,
  output hsc_pkg::lane_t       dn_lane,
  input  logic                 dn_ready
);
  import hsc_pkg::*;

  logic               valid_r;
  lane_t              lane_r;
  lane_t              lane_nxt;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [16:0] xs;
  logic signed [16:0] ys;
  logic [31:0]        fprod;
  logic               advance;

  assign advance  = !valid_r || dn_ready;
  assign up_ready = advance;

  // offset vector, cordic input is x = -dy, y = dx
  always_comb begin
    dx    = {aim_x[15], aim_x} - {pos_x[15], pos_x};
    dy    = {aim_y[15], aim_y} - {pos_y[15], pos_y};
    fprod = 32'(elapsed_time) * 32'(turn_rate);
    lane_nxt.heading = heading;
    lane_nxt.same    = (dx == 17'sd0) && (dy == 17'sd0);
    lane_nxt.factor  = (fprod > 32'(ONE_Q20)) ? ONE_Q20 : FACT_W'(fprod);
    // negative x: turn by a half turn first
    if (dy > 17'sd0) begin
      xs         = dy;
      ys         = -dx;
      lane_nxt.z = HALF_TURN;
    end else begin
      xs         = -dy;
      ys         = dx;
      lane_nxt.z = '0;
    end
    lane_nxt.x = CW'(xs) <<< COORD_FRAC;
    lane_nxt.y = CW'(ys) <<< COORD_FRAC;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      lane_r <= lane_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lane  = lane_r;

endmodule

@@ hw/rtl/hsc_cell.sv @@
// ----------------------------------------------------------------------------
// hsc_cell: one vectoring CORDIC iteration
// Rotates the vector toward the x axis by atan(2^-i) and updates the angle.
// ----------------------------------------------------------------------------
module hsc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [hsc_pkg::SIDX_W-1:0]  stage_idx,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  hsc_pkg::lane_t              up_lane,
  output logic                        dn_valid,
  output hsc_pkg::lane_t              dn_lane,
  input  logic                        dn_ready
);
  import hsc_pkg::*;

  logic                  valid_r;
  lane_t                 lane_r;
  lane_t                 lane_nxt;
  logic signed [CW-1:0]  xs;
  logic signed [CW-1:0]  ys;
  logic [ANGLE_BITS-1:0] ang;
  logic                  advance;

  assign advance  = !valid_r || dn_ready;
  assign up_ready = advance;

  // micro-rotation, clockwise when y is non-negative
  always_comb begin
    lane_nxt = up_lane;
    xs       = up_lane.x >>> stage_idx;
    ys       = up_lane.y >>> stage_idx;
    ang      = atan_const(5'(stage_idx));
    if (!up_lane.y[CW-1]) begin
      lane_nxt.x = up_lane.x + ys;
      lane_nxt.y = up_lane.y - xs;
      lane_nxt.z = up_lane.z + ang;
    end else begin
      lane_nxt.x = up_lane.x - ys;
      lane_nxt.y = up_lane.y + xs;
      lane_nxt.z = up_lane.z - ang;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      lane_r <= lane_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lane  = lane_r;

endmodule

@@ hw/rtl/hsc_finish.sv @@
// ----------------------------------------------------------------------------
// hsc_finish: heading update after the CORDIC
// Shortest signed difference, gain multiply, rounding and output register.
// ----------------------------------------------------------------------------
module hsc_finish (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  hsc_pkg::lane_t   up_lane,
  output logic             out_valid,
  output logic [15:0]      out_new_heading,
  input  logic             out_stall
);
  import hsc_pkg::*;

  logic              va_r, vb_r, vc_r;
  logic              ra, rb, rc;
  logic [15:0]       bearing;
  logic [15:0]       diff;
  logic              neg_nxt;
  logic [15:0]       mag_nxt;
  logic [15:0]       mag_r;
  logic              neg_a_r, same_a_r;
  logic [15:0]       head_a_r;
  logic [FACT_W-1:0] fact_a_r;
  logic [PROD_W-1:0] prod_r;
  logic              neg_b_r, same_b_r;
  logic [15:0]       head_b_r;
  logic [PROD_W-1:0] rsum;
  logic [15:0]       step;
  logic [15:0]       res_nxt;
  logic [15:0]       res_r;

  assign rc       = !vc_r || !out_stall;
  assign rb       = !vb_r || rc;
  assign ra       = !va_r || rb;
  assign up_ready = ra;

  // shortest signed difference, exactly half a turn counts as positive
  always_comb begin
    bearing = bearing16(up_lane.z);
    diff    = bearing - up_lane.heading;
    neg_nxt = diff > 16'h8000;
    mag_nxt = neg_nxt ? (16'd0 - diff) : diff;
  end

  // rounded step, half away from zero
  always_comb begin
    rsum = prod_r + (PROD_W'(1) << 19);
    step = 16'(rsum >> 20);
    if (same_b_r) begin
      res_nxt = head_b_r;
    end else if (neg_b_r) begin
      res_nxt = head_b_r - step;
    end else begin
      res_nxt = head_b_r + step;
    end
  end

  // valid flags of the three stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ra) begin
        va_r <= up_valid;
      end
      if (rb) begin
        vb_r <= va_r;
      end
      if (rc) begin
        vc_r <= vb_r;
      end
    end
  end

  // difference stage
  always_ff @(posedge clk) begin
    if (ra && up_valid) begin
      mag_r    <= mag_nxt;
      neg_a_r  <= neg_nxt;
      same_a_r <= up_lane.same;
      head_a_r <= up_lane.heading;
      fact_a_r <= up_lane.factor;
    end
  end

  // gain multiply stage
  always_ff @(posedge clk) begin
    if (rb && va_r) begin
      prod_r   <= PROD_W'(mag_r) * PROD_W'(fact_a_r);
      neg_b_r  <= neg_a_r;
      same_b_r <= same_a_r;
      head_b_r <= head_a_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rc && vb_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = vc_r;
  assign out_new_heading = res_r;

  a_mag_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> (mag_r <= 16'h8000))
    else $error("difference magnitude above half a turn");

  a_factor_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    va_r |-> (fact_a_r <= ONE_Q20))
    else $error("gain factor above one");

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (prod_r <= (PROD_W'(16'h8000) << 20)))
    else $error("scaled step exceeds half a turn");

endmodule

@@ hw/rtl/heading_slew_toward_point.sv @@
// Path from input accept to result valid: entry register, each CORDIC cell register, difference, gain, output.
// Throughput: one item per cycle while out_stall is low; each CORDIC cell holds one item and hands it on.
// Cells advance independently, so bubbles close up while the output is stalled.
// Reset clears all valid flags and loads turn_rate with 2.0 (512, Q8.8).
// ----------------------------------------------------------------------------
// heading_slew_toward_point: turn a heading toward an aim point
// Bearing by a chain of CORDIC cells, then a clamped-gain move toward it.
// ----------------------------------------------------------------------------
module heading_slew_toward_point (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_aim_x,
  input  logic signed [15:0] in_aim_y,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [15:0]        in_heading,
  input  logic [15:0]        in_elapsed_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_new_heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_turn_rate
);
  import hsc_pkg::*;

  logic [15:0] turn_rate_r;
  logic        in_ready;
  logic        chain_valid [CORDIC_STAGES+1];
  logic        chain_ready [CORDIC_STAGES+1];
  lane_t       chain_lane  [CORDIC_STAGES+1];

  // turn rate register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_rate_r <= 16'd512;
    end else if (cfg_valid && cfg_ready) begin
      turn_rate_r <= cfg_turn_rate;
    end
  end

  // entry stage
  hsc_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .aim_x        (in_aim_x),
    .aim_y        (in_aim_y),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .heading      (in_heading),
    .elapsed_time (in_elapsed_time),
    .turn_rate    (turn_rate_r),
    .dn_valid     (chain_valid[0]),
    .dn_lane      (chain_lane[0]),
    .dn_ready     (chain_ready[0])
  );

  assign in_stall = !in_ready;

  // cordic chain
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    hsc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (SIDX_W'(g)),
      .up_valid  (chain_valid[g]),
      .up_ready  (chain_ready[g]),
      .up_lane   (chain_lane[g]),
      .dn_valid  (chain_valid[g+1]),
      .dn_lane   (chain_lane[g+1]),
      .dn_ready  (chain_ready[g+1])
    );
  end

  // difference, gain and output register
  hsc_finish u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (chain_valid[CORDIC_STAGES]),
    .up_ready        (chain_ready[CORDIC_STAGES]),
    .up_lane         (chain_lane[CORDIC_STAGES]),
    .out_valid       (out_valid),
    .out_new_heading (out_new_heading),
    .out_stall       (out_stall)
  );

  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with nothing waiting at the output");

  a_drain_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output drains");

  a_chain_stall_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (chain_valid[0] && !chain_ready[0]))
    else $error("input stalled while the first cell can take an item");

endmodule
